/* src/fqra_pkg.sv */
`timescale 1ns / 1ps
// Package for the FIFO queue with remove-at unit.
// Holds request and status codes, controller states and the command/status structs.
package fqra_pkg;

  typedef enum logic [1:0] {
    REQ_ENQ    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_SPARE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_HEAD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic enq_write;
    logic shift_rd;
    logic shift_wr;
    logic count_dec;
    logic head_rd;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic kind_enq;
    logic kind_rem;
    logic st_ok;
    logic rm_shift;
    logic shift_more;
    logic out_free;
  } dp_sts_t;

endpackage

/* src/fqra_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the FIFO queue with remove-at unit.
// Depends on fqra_pkg for states and the command/status structs.
module fqra_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fqra_pkg::dp_sts_t sts,
  output fqra_pkg::dp_cmd_t cmd
);
  import fqra_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.kind_rem && sts.st_ok && sts.rm_shift) begin
          state_next = S_SHIFT_RD;
        end else begin
          state_next = S_HEAD;
        end
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (sts.shift_more) begin
          state_next = S_SHIFT_RD;
        end else begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: state_next = S_OUT;
      S_OUT: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECIDE: begin
        cmd.decide    = 1'b1;
        cmd.enq_write = sts.kind_enq && sts.st_ok;
        cmd.count_dec = sts.kind_rem && sts.st_ok && !sts.rm_shift;
      end
      S_SHIFT_RD: cmd.shift_rd = 1'b1;
      S_SHIFT_WR: begin
        cmd.shift_wr  = 1'b1;
        cmd.count_dec = !sts.shift_more;
      end
      S_HEAD: cmd.head_rd = 1'b1;
      S_OUT: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* src/fqra_dp.sv */
`timescale 1ns / 1ps
// Datapath of the FIFO queue with remove-at unit: entry memory, count, pointers
// and the output register. Depends on fqra_pkg for codes and structs.
module fqra_dp #(
  parameter int DEPTH  = 16,
  parameter int ELEM_W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  fqra_pkg::dp_cmd_t cmd,
  output fqra_pkg::dp_sts_t sts,
  input  logic [1:0]        in_req,
  input  logic [31:0]       in_elem,
  input  logic [3:0]        in_pos,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [39:0]       out_data
);
  import fqra_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int AW   = $clog2(DEPTH);
  localparam int CMPW = ((CW > 4) ? CW : 4) + 1;

  logic [ELEM_W-1:0] mem [DEPTH];
  logic [ELEM_W-1:0] rd_data;
  logic [CW-1:0]     count;
  logic [AW-1:0]     idx;
  req_t              req;
  logic [ELEM_W-1:0] val;
  logic [3:0]        pos;
  status_t           st;
  status_t           st_next;

  logic [CMPW-1:0]   pos_c;
  logic [CMPW-1:0]   cnt_c;
  logic [CW:0]       idx_c;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [ELEM_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [31:0]       head_out;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= req_t'(in_req);
      val <= ELEM_W'($signed(in_elem));
      pos <= in_pos;
    end
  end

  assign pos_c = CMPW'(pos);
  assign cnt_c = CMPW'(count);
  assign idx_c = (CW + 1)'(idx);

  always_comb begin
    st_next = ST_OK;
    case (req)
      REQ_ENQ: begin
        if (count == CW'(DEPTH)) begin
          st_next = ST_FULL;
        end
      end
      REQ_REMOVE: begin
        if (count == '0) begin
          st_next = ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          st_next = ST_RANGE;
        end
      end
      default: st_next = ST_OK;
    endcase
  end

  assign sts.kind_enq   = (req == REQ_ENQ);
  assign sts.kind_rem   = (req == REQ_REMOVE);
  assign sts.st_ok      = (st_next == ST_OK);
  assign sts.rm_shift   = (pos_c + CMPW'(1)) < cnt_c;
  assign sts.shift_more = (idx_c + (CW + 1)'(2)) < (CW + 1)'(count);
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      st  <= st_next;
      idx <= AW'(pos);
    end else if (cmd.shift_wr) begin
      idx <= idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.enq_write) begin
      count <= count + CW'(1);
    end else if (cmd.count_dec) begin
      count <= count - CW'(1);
    end
  end

  assign wr_en   = cmd.enq_write || cmd.shift_wr;
  assign wr_addr = cmd.enq_write ? AW'(count) : idx;
  assign wr_data = cmd.enq_write ? val : rd_data;
  assign rd_en   = cmd.shift_rd || cmd.head_rd;
  assign rd_addr = cmd.shift_rd ? (idx + AW'(1)) : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign head_out = (count == '0) ? 32'd0 : 32'($signed(rd_data));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {st, 5'(count), (count == '0), head_out};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (CW + 1)'(count) <= (CW + 1)'(DEPTH))
    else $error("Element count exceeds the queue depth.");

  a_enq_room: assert property (@(posedge clk) disable iff (rst)
    cmd.enq_write |-> ((CW + 1)'(count) < (CW + 1)'(DEPTH)))
    else $error("Enqueue write issued on a full queue.");

  a_shift_inside: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_wr |-> ((idx_c + (CW + 1)'(1)) < (CW + 1)'(count)))
    else $error("Shift step reaches past the held entries.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("Result word overwritten before it was taken.");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    !(cmd.enq_write && cmd.count_dec) && !(cmd.shift_rd && cmd.shift_wr))
    else $error("Conflicting datapath commands in one cycle.");

endmodule

/* src/fifo_queue_with_remove_at_unit.sv */
`timescale 1ns / 1ps
// FIFO queue with remove-at unit: top level joining controller and datapath.
// Enqueue, peek and refused requests pass the decide, head-read and output states;
// the result word loads once the output register is free, and the next request is
// taken only then. A removal adds a shift read and write for each entry behind the
// removed one: one memory read and one write per entry through the entry memory.
// One request is in work at a time; rst clears count, controller and output valid.
module fifo_queue_with_remove_at_unit #(
  parameter int DEPTH  = 16,
  parameter int ELEM_W = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // elem_value[31:0], position[35:32], zero[39:36]
  input  logic [1:0]  s_tuser,  // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // head_value[31:0], is_empty[32], count[37:33],
                                // status[39:38]
);
  import fqra_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  fqra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fqra_dp #(
    .DEPTH  (DEPTH),
    .ELEM_W (ELEM_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_req    (s_tuser),
    .in_elem   (s_tdata[31:0]),
    .in_pos    (s_tdata[35:32]),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

endmodule
